@@ hdl/fote_pkg.sv @@
// ---------------------------------------------------------------------------
// fote_pkg
// Shared widths, register indexes, mode codes and tone coefficients of the
// frame orient and tone engine.
// ---------------------------------------------------------------------------
package fote_pkg;

  // frame geometry
  localparam int MAX_DIM    = 256;
  localparam int MAX_PIXELS = 65536;
  localparam int DIM_W      = $clog2(MAX_DIM + 1);      // holds 1..MAX_DIM
  localparam int POS_W      = $clog2(MAX_DIM);          // holds 0..MAX_DIM-1
  localparam int ADDR_W     = $clog2(MAX_PIXELS);
  localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
  localparam int TOT_W      = 2 * DIM_W;
  localparam int CMP_W      = (TOT_W > CNT_W) ? TOT_W : CNT_W;
  localparam int PROD_W     = POS_W + DIM_W;

  // channel field widths
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 3 * CHAN_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int MODE_W     = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd2;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_ROW_REV = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MIRROR  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ROT_CW  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ROT_CCW = 3'd3;
  localparam logic [MODE_W-1:0] MODE_GRAY    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SEPIA   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_PASS    = 3'd6;

  // input opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // weighted sums, per thousand
  localparam int SUM_W  = 19;   // largest sum is 1351 * 255
  localparam int COEF_W = 10;
  localparam logic [COEF_W-1:0] GRAY_R  = 10'd300;
  localparam logic [COEF_W-1:0] GRAY_G  = 10'd600;
  localparam logic [COEF_W-1:0] GRAY_B  = 10'd100;
  localparam logic [COEF_W-1:0] SEP_RR  = 10'd393;
  localparam logic [COEF_W-1:0] SEP_RG  = 10'd769;
  localparam logic [COEF_W-1:0] SEP_RB  = 10'd189;
  localparam logic [COEF_W-1:0] SEP_GR  = 10'd349;
  localparam logic [COEF_W-1:0] SEP_GG  = 10'd686;
  localparam logic [COEF_W-1:0] SEP_GB  = 10'd168;
  localparam logic [COEF_W-1:0] SEP_BR  = 10'd272;
  localparam logic [COEF_W-1:0] SEP_BG  = 10'd534;
  localparam logic [COEF_W-1:0] SEP_BB  = 10'd131;

  // divide by one thousand as multiply by ceil(2^29 / 1000), exact below 2^19
  localparam int RECIP_SHIFT = 29;
  localparam int RECIP_W     = 20;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 20'd536871;
  localparam int MUL_W       = SUM_W + RECIP_W;
  localparam int QUO_W       = MUL_W - RECIP_SHIFT;

endpackage

@@ hdl/fote_in_if.sv @@
// ---------------------------------------------------------------------------
// fote_in_if
// Input channel: pixel loads and fetch requests with valid/ready.
// ---------------------------------------------------------------------------
interface fote_in_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [fote_pkg::CHAN_W-1:0] red_in;
  logic [fote_pkg::CHAN_W-1:0] green_in;
  logic [fote_pkg::CHAN_W-1:0] blue_in;

  modport source (output valid, opcode, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, opcode, red_in, green_in, blue_in, output ready);
endinterface

@@ hdl/fote_out_if.sv @@
// ---------------------------------------------------------------------------
// fote_out_if
// Result channel: output pixels and frame flags with valid/ready.
// ---------------------------------------------------------------------------
interface fote_out_if;
  logic                        valid;
  logic                        ready;
  logic [fote_pkg::CHAN_W-1:0] red_out;
  logic [fote_pkg::CHAN_W-1:0] green_out;
  logic [fote_pkg::CHAN_W-1:0] blue_out;
  logic                        last_pixel;
  logic                        frame_incomplete;

  modport source (output valid, red_out, green_out, blue_out, last_pixel,
                  frame_incomplete, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, last_pixel,
                  frame_incomplete, output ready);
endinterface

@@ hdl/fote_cfg_if.sv @@
// ---------------------------------------------------------------------------
// fote_cfg_if
// Configuration write channel: register index and data with valid/ready.
// ---------------------------------------------------------------------------
interface fote_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fote_pkg::CFG_IDX_W-1:0]  index;
  logic [fote_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/frame_orient_and_tone_engine_top.sv @@
// ---------------------------------------------------------------------------
// frame_orient_and_tone_engine_top
// Frame store with reordering read-back and sepia / red-only gray recoloring.
// ---------------------------------------------------------------------------
// A load transfer writes one pixel into the frame store while the frame is not
// yet full, so loads stream at one per cycle while no fetch is in flight. A
// fetch transfer passes through the frame store read (registered), the
// weighted-sum stage and the divide-by-thousand stage (a reciprocal multiply)
// before its result sits in the output register; the input side then takes the
// next transfer while the result waits on the output side, and a fetch only
// stalls in its last stage when an earlier result has still not been taken. The
// frame store is not cleared after reset and needs no clearing pass; pixels
// are returned only once the whole frame has been loaded. Configuration writes
// are always accepted and must only be issued while no fetch is in flight.
module frame_orient_and_tone_engine_top (
  input  logic       clk,
  input  logic       rst_n,
  fote_in_if.sink    in_ch,
  fote_out_if.source out_ch,
  fote_cfg_if.sink   cfg_ch
);

  typedef enum logic [1:0] {S_IDLE, S_SUM, S_DIV} state_t;

  // clamp a written dimension into 1..MAX_DIM
  function automatic logic [fote_pkg::DIM_W-1:0] clamp_dim(
    input logic [fote_pkg::CFG_DATA_W-1:0] v
  );
    logic [fote_pkg::DIM_W-1:0] res;
    if (v == '0) begin
      res = fote_pkg::DIM_W'(1);
    end else if (int'(v) > fote_pkg::MAX_DIM) begin
      res = fote_pkg::DIM_W'(fote_pkg::MAX_DIM);
    end else begin
      res = fote_pkg::DIM_W'(v);
    end
    return res;
  endfunction

  function automatic logic [fote_pkg::CHAN_W-1:0] sat8(
    input logic [fote_pkg::QUO_W-1:0] v
  );
    logic [fote_pkg::CHAN_W-1:0] res;
    if (v > fote_pkg::QUO_W'(255)) begin
      res = '1;
    end else begin
      res = v[fote_pkg::CHAN_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [fote_pkg::QUO_W-1:0] div1000(
    input logic [fote_pkg::SUM_W-1:0] v
  );
    logic [fote_pkg::MUL_W-1:0] prod;
    prod = fote_pkg::MUL_W'(v) * fote_pkg::MUL_W'(fote_pkg::RECIP_1000);
    return prod[fote_pkg::MUL_W-1:fote_pkg::RECIP_SHIFT];
  endfunction

  // frame store
  logic [fote_pkg::PIX_W-1:0] frame_mem [fote_pkg::MAX_PIXELS];
  logic [fote_pkg::PIX_W-1:0] rd_q_r;

  // control registers
  state_t                      state_r, state_nxt;
  logic [fote_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic [fote_pkg::DIM_W-1:0]  rows_r, rows_nxt;
  logic [fote_pkg::DIM_W-1:0]  cols_r, cols_nxt;
  logic [fote_pkg::CNT_W-1:0]  load_cnt_r, load_cnt_nxt;
  logic [fote_pkg::POS_W-1:0]  out_row_r, out_row_nxt;
  logic [fote_pkg::POS_W-1:0]  out_col_r, out_col_nxt;
  logic                        out_valid_r, out_valid_nxt;

  // pipeline payload
  logic                        inc_r, inc_nxt;
  logic                        last_r, last_nxt;
  logic [fote_pkg::SUM_W-1:0]  sum0_r, sum0_nxt;
  logic [fote_pkg::SUM_W-1:0]  sum1_r, sum1_nxt;
  logic [fote_pkg::SUM_W-1:0]  sum2_r, sum2_nxt;
  logic [fote_pkg::CHAN_W-1:0] red_r, red_nxt;
  logic [fote_pkg::CHAN_W-1:0] green_r, green_nxt;
  logic [fote_pkg::CHAN_W-1:0] blue_r, blue_nxt;
  logic                        olast_r, olast_nxt;
  logic                        oinc_r, oinc_nxt;

  // combinational helpers
  logic                         in_xfer, load_xfer, fetch_xfer, cfg_xfer;
  logic [fote_pkg::CMP_W-1:0]   total;
  logic                         frame_done, load_room, rotated;
  logic [fote_pkg::DIM_W-1:0]   orows, ocols;
  logic [fote_pkg::POS_W-1:0]   eff_row, eff_col, src_row, src_col;
  logic                         row_last, col_last;
  logic [fote_pkg::PROD_W-1:0]  addr_full;
  logic [fote_pkg::ADDR_W-1:0]  rd_addr;
  logic [fote_pkg::CHAN_W-1:0]  q_r, q_g, q_b;
  logic [fote_pkg::QUO_W-1:0]   quo0, quo1, quo2;
  logic                         out_free;

  // handshakes
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign load_xfer    = in_xfer && (in_ch.opcode == fote_pkg::OP_LOAD) && load_room;
  assign fetch_xfer   = in_xfer && (in_ch.opcode == fote_pkg::OP_FETCH);
  assign cfg_xfer     = cfg_ch.valid && cfg_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;

  // frame fill status
  assign total      = fote_pkg::CMP_W'(rows_r) * fote_pkg::CMP_W'(cols_r);
  assign frame_done = fote_pkg::CMP_W'(load_cnt_r) >= total;
  assign load_room  = !frame_done &&
                      (load_cnt_r < fote_pkg::CNT_W'(fote_pkg::MAX_PIXELS));

  // output geometry and current position
  assign rotated = (mode_r == fote_pkg::MODE_ROT_CW) || (mode_r == fote_pkg::MODE_ROT_CCW);
  assign orows   = rotated ? cols_r : rows_r;
  assign ocols   = rotated ? rows_r : cols_r;
  assign eff_row = (fote_pkg::DIM_W'(out_row_r) >= orows) ? '0 : out_row_r;
  assign eff_col = (fote_pkg::DIM_W'(out_col_r) >= ocols) ? '0 : out_col_r;
  assign row_last = (fote_pkg::DIM_W'(eff_row) == orows - fote_pkg::DIM_W'(1));
  assign col_last = (fote_pkg::DIM_W'(eff_col) == ocols - fote_pkg::DIM_W'(1));

  // source pixel of the current output position
  always_comb begin
    case (mode_r)
      fote_pkg::MODE_ROW_REV: begin
        src_row = fote_pkg::POS_W'(rows_r - fote_pkg::DIM_W'(1) - fote_pkg::DIM_W'(eff_row));
        src_col = eff_col;
      end
      fote_pkg::MODE_MIRROR: begin
        src_row = eff_row;
        src_col = fote_pkg::POS_W'(cols_r - fote_pkg::DIM_W'(1) - fote_pkg::DIM_W'(eff_col));
      end
      fote_pkg::MODE_ROT_CW: begin
        src_row = fote_pkg::POS_W'(rows_r - fote_pkg::DIM_W'(1) - fote_pkg::DIM_W'(eff_col));
        src_col = eff_row;
      end
      fote_pkg::MODE_ROT_CCW: begin
        src_row = eff_col;
        src_col = fote_pkg::POS_W'(cols_r - fote_pkg::DIM_W'(1) - fote_pkg::DIM_W'(eff_row));
      end
      default: begin
        src_row = eff_row;
        src_col = eff_col;
      end
    endcase
  end

  assign addr_full = fote_pkg::PROD_W'(src_row) * fote_pkg::PROD_W'(cols_r)
                   + fote_pkg::PROD_W'(src_col);
  assign rd_addr   = addr_full[fote_pkg::ADDR_W-1:0];

  // frame store write and registered read
  always_ff @(posedge clk) begin
    if (load_xfer) begin
      frame_mem[load_cnt_r[fote_pkg::ADDR_W-1:0]] <= {in_ch.red_in, in_ch.green_in,
                                                     in_ch.blue_in};
    end
    if (fetch_xfer) begin
      rd_q_r <= frame_mem[rd_addr];
    end
  end

  assign q_r = rd_q_r[fote_pkg::PIX_W-1 -: fote_pkg::CHAN_W];
  assign q_g = rd_q_r[fote_pkg::CHAN_W +: fote_pkg::CHAN_W];
  assign q_b = rd_q_r[0 +: fote_pkg::CHAN_W];

  assign quo0 = div1000(sum0_r);
  assign quo1 = div1000(sum1_r);
  assign quo2 = div1000(sum2_r);

  // next-state logic
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    rows_nxt      = rows_r;
    cols_nxt      = cols_r;
    load_cnt_nxt  = load_cnt_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    inc_nxt       = inc_r;
    last_nxt      = last_r;
    sum0_nxt      = sum0_r;
    sum1_nxt      = sum1_r;
    sum2_nxt      = sum2_r;
    red_nxt       = red_r;
    green_nxt     = green_r;
    blue_nxt      = blue_r;
    olast_nxt     = olast_r;
    oinc_nxt      = oinc_r;

    // load fills the next store entry
    if (load_xfer) begin
      load_cnt_nxt = load_cnt_r + fote_pkg::CNT_W'(1);
    end

    case (state_r)
      S_IDLE: begin
        if (fetch_xfer) begin
          state_nxt = S_SUM;
          inc_nxt   = !frame_done;
          last_nxt  = row_last && col_last;
          // raster advance of the output position
          if (frame_done) begin
            if (col_last) begin
              out_col_nxt = '0;
              out_row_nxt = row_last ? '0 : eff_row + fote_pkg::POS_W'(1);
            end else begin
              out_col_nxt = eff_col + fote_pkg::POS_W'(1);
              out_row_nxt = eff_row;
            end
          end
        end
      end
      S_SUM: begin
        // weighted sums of the fetched pixel
        state_nxt = S_DIV;
        if (mode_r == fote_pkg::MODE_GRAY) begin
          sum0_nxt = fote_pkg::SUM_W'(q_r) * fote_pkg::SUM_W'(fote_pkg::GRAY_R)
                   + fote_pkg::SUM_W'(q_g) * fote_pkg::SUM_W'(fote_pkg::GRAY_G)
                   + fote_pkg::SUM_W'(q_b) * fote_pkg::SUM_W'(fote_pkg::GRAY_B);
        end else begin
          sum0_nxt = fote_pkg::SUM_W'(q_r) * fote_pkg::SUM_W'(fote_pkg::SEP_RR)
                   + fote_pkg::SUM_W'(q_g) * fote_pkg::SUM_W'(fote_pkg::SEP_RG)
                   + fote_pkg::SUM_W'(q_b) * fote_pkg::SUM_W'(fote_pkg::SEP_RB);
        end
        sum1_nxt = fote_pkg::SUM_W'(q_r) * fote_pkg::SUM_W'(fote_pkg::SEP_GR)
                 + fote_pkg::SUM_W'(q_g) * fote_pkg::SUM_W'(fote_pkg::SEP_GG)
                 + fote_pkg::SUM_W'(q_b) * fote_pkg::SUM_W'(fote_pkg::SEP_GB);
        sum2_nxt = fote_pkg::SUM_W'(q_r) * fote_pkg::SUM_W'(fote_pkg::SEP_BR)
                 + fote_pkg::SUM_W'(q_g) * fote_pkg::SUM_W'(fote_pkg::SEP_BG)
                 + fote_pkg::SUM_W'(q_b) * fote_pkg::SUM_W'(fote_pkg::SEP_BB);
      end
      S_DIV: begin
        // divide, saturate and hand over to the output register
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          olast_nxt     = inc_r ? 1'b0 : last_r;
          oinc_nxt      = inc_r;
          if (inc_r) begin
            red_nxt   = '0;
            green_nxt = '0;
            blue_nxt  = '0;
          end else if (mode_r == fote_pkg::MODE_GRAY) begin
            red_nxt   = quo0[fote_pkg::CHAN_W-1:0];
            green_nxt = q_g;
            blue_nxt  = q_b;
          end else if (mode_r == fote_pkg::MODE_SEPIA) begin
            red_nxt   = sat8(quo0);
            green_nxt = sat8(quo1);
            blue_nxt  = sat8(quo2);
          end else begin
            red_nxt   = q_r;
            green_nxt = q_g;
            blue_nxt  = q_b;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // register writes restart the output position
    if (cfg_xfer) begin
      case (cfg_ch.index)
        fote_pkg::CFG_MODE: begin
          mode_nxt    = cfg_ch.data[fote_pkg::MODE_W-1:0];
          out_row_nxt = '0;
          out_col_nxt = '0;
        end
        fote_pkg::CFG_ROWS: begin
          rows_nxt     = clamp_dim(cfg_ch.data);
          load_cnt_nxt = '0;
          out_row_nxt  = '0;
          out_col_nxt  = '0;
        end
        fote_pkg::CFG_COLS: begin
          cols_nxt     = clamp_dim(cfg_ch.data);
          load_cnt_nxt = '0;
          out_row_nxt  = '0;
          out_col_nxt  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // state, control and output registers
  always_ff @(posedge clk) begin
    inc_r   <= inc_nxt;
    last_r  <= last_nxt;
    sum0_r  <= sum0_nxt;
    sum1_r  <= sum1_nxt;
    sum2_r  <= sum2_nxt;
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
    olast_r <= olast_nxt;
    oinc_r  <= oinc_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= fote_pkg::MODE_PASS;
      rows_r      <= fote_pkg::DIM_W'(1);
      cols_r      <= fote_pkg::DIM_W'(1);
      load_cnt_r  <= '0;
      out_row_r   <= '0;
      out_col_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      rows_r      <= rows_nxt;
      cols_r      <= cols_nxt;
      load_cnt_r  <= load_cnt_nxt;
      out_row_r   <= out_row_nxt;
      out_col_r   <= out_col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result channel
  assign out_ch.valid            = out_valid_r;
  assign out_ch.red_out          = red_r;
  assign out_ch.green_out        = green_r;
  assign out_ch.blue_out         = blue_r;
  assign out_ch.last_pixel       = olast_r;
  assign out_ch.frame_incomplete = oinc_r;

  // fill count never runs past the store
  a_load_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    load_cnt_r <= fote_pkg::CNT_W'(fote_pkg::MAX_PIXELS))
    else $error("load count beyond frame store");

  // a fetch transfer blocks the input side while it is in flight
  a_fetch_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.opcode == fote_pkg::OP_FETCH)) |=> !in_ch.ready)
    else $error("input accepted during fetch");

  // an early fetch carries a blank pixel
  a_incomplete_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.frame_incomplete) |->
      (out_ch.red_out == '0) && (out_ch.green_out == '0) && (out_ch.blue_out == '0) &&
      !out_ch.last_pixel)
    else $error("incomplete-frame result not blank");

  // a pending result is not overwritten by a finishing fetch
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> out_valid_r && $stable(red_r) && $stable(oinc_r))
    else $error("pending result overwritten");

endmodule
